// File: hw/rtl/dynamic_lightmap_texel_accumulate_core_macros.svh
// Assertion macros for the texel accumulate core.
// Used by modules that check their own control logic; needs clk_i and rst_ni in scope.
`ifndef DYNAMIC_LIGHTMAP_TEXEL_ACCUMULATE_CORE_MACROS_SVH
`define DYNAMIC_LIGHTMAP_TEXEL_ACCUMULATE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DLTA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DLTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/dlta_pkg.sv
// Shared types and constants of the texel accumulate core.
// No dependencies; used by dlta_ctrl, dlta_datapath and the top level.
package dlta_pkg;

  localparam int unsigned COORD_W    = 24;
  localparam int unsigned VAL_W      = 8;
  localparam int unsigned BRIGHT_W   = 16;
  localparam int unsigned RADIUS_W   = 16;
  localparam int unsigned MAG_W      = 24;
  localparam int unsigned D2_W       = 50;
  localparam int unsigned DIGIT_W    = 8;
  localparam int unsigned MUL_B_W    = 32;
  localparam int unsigned MUL_CNT_W  = 2;
  localparam int unsigned DIV_STEPS  = 9;
  localparam int unsigned DIV_CNT_W  = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [MUL_CNT_W-1:0] SQ_DIGITS    = 2'd3;
  localparam logic [MUL_CNT_W-1:0] RAD_DIGITS   = 2'd2;
  localparam logic [MUL_CNT_W-1:0] BRI_DIGITS   = 2'd2;
  localparam logic [MUL_CNT_W-1:0] PLANE_DIGITS = 2'd3;

  localparam logic [VAL_W-1:0]    LIGHT_THRESHOLD = 8'd8;
  localparam logic [VAL_W-1:0]    DARK_THRESHOLD  = 8'd52;
  localparam logic [VAL_W-1:0]    VALUE_MAX       = 8'd255;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET    = 16'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIGHT_X        = 3'd0,
    CFG_LIGHT_Y        = 3'd1,
    CFG_LIGHT_Z        = 3'd2,
    CFG_BRIGHTNESS     = 3'd3,
    CFG_PLANE_DISTANCE = 3'd4,
    CFG_RADIUS_SQUARED = 3'd5,
    CFG_DARKEN_MODE    = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MUL_SQ_X,
    MUL_SQ_Y,
    MUL_SQ_Z,
    MUL_DEN,
    MUL_NUM_B,
    MUL_NUM_P
  } mul_op_e;

  typedef enum logic [1:0] {
    C_ZERO,
    C_MAX,
    C_QUOT
  } c_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_CHECK,
    ST_DEN,
    ST_NUM_B,
    ST_NUM_P,
    ST_DIV,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] texel_x;
    logic signed [COORD_W-1:0] texel_y;
    logic signed [COORD_W-1:0] texel_z;
    logic [VAL_W-1:0]          old_value;
    logic                      last_texel;
  } texel_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] new_value;
    logic             changed;
    logic             end_of_map;
    logic             any_changed;
  } texel_rsp_t;

  typedef struct packed {
    logic    item_load;
    logic    mul_load;
    mul_op_e mul_op;
    logic    d2_clear;
    logic    d2_add;
    logic    den_store;
    logic    div_init;
    logic    c_load;
    c_sel_e  c_sel;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic d2_gt_rq;
    logic d2_zero;
    logic num_nonpos;
  } sts_t;

endpackage

// File: hw/rtl/dlta_datapath.sv
// Datapath: config registers, digit-serial multiplier, restoring divider, result register.
// Depends on dlta_pkg; driven by dlta_ctrl through dlta_pkg::cmd_t.
module dlta_datapath #(
  parameter int unsigned COORD_FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [dlta_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dlta_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  dlta_pkg::texel_req_t                in_req_i,
  input  dlta_pkg::cmd_t                      cmd_i,
  output dlta_pkg::sts_t                      sts_o,
  output dlta_pkg::texel_rsp_t                out_rsp_o
);

  localparam int unsigned RQ_SH  = 2 * COORD_FRAC_BITS - 8;
  localparam int unsigned RQ_W   = dlta_pkg::RADIUS_W + RQ_SH;
  localparam int unsigned A_W    = RQ_W + dlta_pkg::BRIGHT_W;
  localparam int unsigned PP_W   = A_W + dlta_pkg::DIGIT_W;
  localparam int unsigned ACC_W  = A_W + dlta_pkg::MUL_B_W;
  localparam int unsigned DEN_W  = A_W;
  localparam int unsigned NUM_W  = A_W + dlta_pkg::COORD_W;
  localparam int unsigned DD_SH  = COORD_FRAC_BITS + 8;
  localparam int unsigned DIV_W  = (DEN_W + DD_SH > NUM_W) ? DEN_W + DD_SH : NUM_W;
  localparam int unsigned CW     = dlta_pkg::COORD_W;
  localparam int unsigned VW     = dlta_pkg::VAL_W;

  logic [CW-1:0]                     light_x_q, light_y_q, light_z_q, plane_q;
  logic [dlta_pkg::BRIGHT_W-1:0]     bright_q;
  logic [dlta_pkg::RADIUS_W-1:0]     rs_q;
  logic                              darken_q;
  dlta_pkg::texel_req_t              texel_q;

  logic [CW-1:0]                     lsel, tsel;
  logic [CW:0]                       diff;
  logic [CW:0]                       diff_abs;
  logic [dlta_pkg::MAG_W-1:0]        mag;
  logic [RQ_W-1:0]                   rq;

  logic [A_W-1:0]                    a_q, a_ld;
  logic [dlta_pkg::MUL_B_W-1:0]      b_q, b_ld;
  logic [dlta_pkg::MUL_CNT_W-1:0]    mul_cnt_q, mul_cnt_ld;
  logic [ACC_W-1:0]                  acc_q, acc_step;
  logic [dlta_pkg::DIGIT_W-1:0]      digit;
  logic [PP_W-1:0]                   pp;

  logic [dlta_pkg::D2_W-1:0]         d2_q;
  logic [DEN_W-1:0]                  den_q;
  logic [DIV_W-1:0]                  rem_q, dd_q;
  logic [dlta_pkg::DIV_STEPS-1:0]    quot_q;
  logic [dlta_pkg::DIV_CNT_W-1:0]    div_cnt_q;
  logic                              div_ge;
  logic [VW-1:0]                     c_q;

  logic [VW:0]                       sum;
  logic [VW-1:0]                     nv;
  logic                              chg;
  logic                              any;
  logic                              touched_q;
  dlta_pkg::texel_rsp_t              rsp_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_x_q <= '0;
      light_y_q <= '0;
      light_z_q <= '0;
      bright_q  <= '0;
      plane_q   <= '0;
      rs_q      <= dlta_pkg::RADIUS_RESET;
      darken_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (dlta_pkg::cfg_idx_e'(cfg_index_i))
        dlta_pkg::CFG_LIGHT_X:        light_x_q <= cfg_data_i;
        dlta_pkg::CFG_LIGHT_Y:        light_y_q <= cfg_data_i;
        dlta_pkg::CFG_LIGHT_Z:        light_z_q <= cfg_data_i;
        dlta_pkg::CFG_BRIGHTNESS:     bright_q  <= cfg_data_i[dlta_pkg::BRIGHT_W-1:0];
        dlta_pkg::CFG_PLANE_DISTANCE: plane_q   <= cfg_data_i;
        dlta_pkg::CFG_RADIUS_SQUARED: rs_q      <= cfg_data_i[dlta_pkg::RADIUS_W-1:0];
        dlta_pkg::CFG_DARKEN_MODE:    darken_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      texel_q <= in_req_i;
    end
  end

  // axis distance magnitude
  always_comb begin
    unique case (cmd_i.mul_op)
      dlta_pkg::MUL_SQ_Y: begin
        lsel = light_y_q;
        tsel = texel_q.texel_y;
      end
      dlta_pkg::MUL_SQ_Z: begin
        lsel = light_z_q;
        tsel = texel_q.texel_z;
      end
      default: begin
        lsel = light_x_q;
        tsel = texel_q.texel_x;
      end
    endcase
  end

  assign diff     = {lsel[CW-1], lsel} - {tsel[CW-1], tsel};
  assign diff_abs = diff[CW] ? (~diff + 1'b1) : diff;
  assign mag      = diff_abs[dlta_pkg::MAG_W-1:0];
  assign rq       = RQ_W'(rs_q) << RQ_SH;

  // multiplier operand load
  always_comb begin
    unique case (cmd_i.mul_op)
      dlta_pkg::MUL_DEN: begin
        a_ld       = A_W'(d2_q[RQ_W-1:0]);
        b_ld       = {rs_q, 16'b0};
        mul_cnt_ld = dlta_pkg::RAD_DIGITS;
      end
      dlta_pkg::MUL_NUM_B: begin
        a_ld       = A_W'(rq - d2_q[RQ_W-1:0]);
        b_ld       = {bright_q, 16'b0};
        mul_cnt_ld = dlta_pkg::BRI_DIGITS;
      end
      dlta_pkg::MUL_NUM_P: begin
        a_ld       = acc_q[A_W-1:0];
        b_ld       = {plane_q, 8'b0};
        mul_cnt_ld = dlta_pkg::PLANE_DIGITS;
      end
      default: begin
        a_ld       = A_W'(mag);
        b_ld       = {mag, 8'b0};
        mul_cnt_ld = dlta_pkg::SQ_DIGITS;
      end
    endcase
  end

  // one 8-bit digit of B per cycle, most significant first
  assign digit    = b_q[dlta_pkg::MUL_B_W-1 -: dlta_pkg::DIGIT_W];
  assign pp       = PP_W'(a_q) * PP_W'(digit);
  assign acc_step = (acc_q << dlta_pkg::DIGIT_W) + ACC_W'(pp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_cnt_q <= '0;
    end else if (cmd_i.mul_load) begin
      mul_cnt_q <= mul_cnt_ld;
    end else if (mul_cnt_q != '0) begin
      mul_cnt_q <= mul_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      a_q   <= a_ld;
      b_q   <= b_ld;
      acc_q <= '0;
    end else if (mul_cnt_q != '0) begin
      acc_q <= acc_step;
      b_q   <= b_q << dlta_pkg::DIGIT_W;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.d2_clear) begin
      d2_q <= '0;
    end else if (cmd_i.d2_add) begin
      d2_q <= d2_q + acc_q[dlta_pkg::D2_W-1:0];
    end
    if (cmd_i.den_store) begin
      den_q <= acc_q[DEN_W-1:0];
    end
  end

  // restoring divider: saturation bit then eight quotient bits
  assign div_ge = (rem_q >= dd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      div_cnt_q <= dlta_pkg::DIV_CNT_W'(dlta_pkg::DIV_STEPS);
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q  <= DIV_W'(acc_q[NUM_W-1:0]);
      dd_q   <= DIV_W'(den_q) << DD_SH;
      quot_q <= '0;
    end else if (div_cnt_q != '0) begin
      rem_q  <= div_ge ? (rem_q - dd_q) : rem_q;
      dd_q   <= dd_q >> 1;
      quot_q <= {quot_q[dlta_pkg::DIV_STEPS-2:0], div_ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.c_load) begin
      unique case (cmd_i.c_sel)
        dlta_pkg::C_MAX:  c_q <= dlta_pkg::VALUE_MAX;
        dlta_pkg::C_QUOT: c_q <= quot_q[VW] ? dlta_pkg::VALUE_MAX : quot_q[VW-1:0];
        default:          c_q <= '0;
      endcase
    end
  end

  // texel update
  assign sum = {1'b0, texel_q.old_value} + {1'b0, c_q};

  always_comb begin
    if (darken_q) begin
      chg = (c_q > dlta_pkg::DARK_THRESHOLD);
      nv  = !chg ? texel_q.old_value :
            (texel_q.old_value > c_q) ? (texel_q.old_value - c_q) : '0;
    end else begin
      chg = (c_q > dlta_pkg::LIGHT_THRESHOLD);
      nv  = !chg ? texel_q.old_value :
            sum[VW] ? dlta_pkg::VALUE_MAX : sum[VW-1:0];
    end
  end

  assign any = touched_q | chg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touched_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      touched_q <= texel_q.last_texel ? 1'b0 : any;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rsp_q.new_value   <= nv;
      rsp_q.changed     <= chg;
      rsp_q.end_of_map  <= texel_q.last_texel;
      rsp_q.any_changed <= any;
    end
  end

  assign out_rsp_o = rsp_q;

  assign sts_o.mul_done   = (mul_cnt_q == '0);
  assign sts_o.div_done   = (div_cnt_q == '0);
  assign sts_o.d2_gt_rq   = (d2_q > dlta_pkg::D2_W'(rq));
  assign sts_o.d2_zero    = (d2_q == '0);
  assign sts_o.num_nonpos = plane_q[CW-1] || (plane_q == '0) || (bright_q == '0);

endmodule

// File: hw/rtl/dlta_ctrl.sv
// Controller state machine sequencing the multiplier, divider and result register.
// Depends on dlta_pkg and dynamic_lightmap_texel_accumulate_core_macros.svh.
`include "dynamic_lightmap_texel_accumulate_core_macros.svh"

module dlta_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  dlta_pkg::sts_t  sts_i,
  output dlta_pkg::cmd_t  cmd_o
);

  dlta_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dlta_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dlta_pkg::ST_IDLE:  if (in_valid_i) state_d = dlta_pkg::ST_LOAD;
      dlta_pkg::ST_LOAD:  state_d = dlta_pkg::ST_SQ_X;
      dlta_pkg::ST_SQ_X:  if (sts_i.mul_done) state_d = dlta_pkg::ST_SQ_Y;
      dlta_pkg::ST_SQ_Y:  if (sts_i.mul_done) state_d = dlta_pkg::ST_SQ_Z;
      dlta_pkg::ST_SQ_Z:  if (sts_i.mul_done) state_d = dlta_pkg::ST_CHECK;
      dlta_pkg::ST_CHECK: begin
        if (sts_i.d2_gt_rq || sts_i.d2_zero || sts_i.num_nonpos) begin
          state_d = dlta_pkg::ST_WRITE;
        end else begin
          state_d = dlta_pkg::ST_DEN;
        end
      end
      dlta_pkg::ST_DEN:   if (sts_i.mul_done) state_d = dlta_pkg::ST_NUM_B;
      dlta_pkg::ST_NUM_B: if (sts_i.mul_done) state_d = dlta_pkg::ST_NUM_P;
      dlta_pkg::ST_NUM_P: if (sts_i.mul_done) state_d = dlta_pkg::ST_DIV;
      dlta_pkg::ST_DIV:   if (sts_i.div_done) state_d = dlta_pkg::ST_WRITE;
      dlta_pkg::ST_WRITE: if (out_free) state_d = dlta_pkg::ST_IDLE;
      default:            state_d = dlta_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.mul_op = dlta_pkg::MUL_SQ_X;
    cmd_o.c_sel  = dlta_pkg::C_ZERO;
    in_ready_o   = 1'b0;
    unique case (state_q)
      dlta_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.item_load = in_valid_i;
      end
      dlta_pkg::ST_LOAD: begin
        cmd_o.mul_load = 1'b1;
        cmd_o.d2_clear = 1'b1;
      end
      dlta_pkg::ST_SQ_X: begin
        cmd_o.mul_op   = dlta_pkg::MUL_SQ_Y;
        cmd_o.mul_load = sts_i.mul_done;
        cmd_o.d2_add   = sts_i.mul_done;
      end
      dlta_pkg::ST_SQ_Y: begin
        cmd_o.mul_op   = dlta_pkg::MUL_SQ_Z;
        cmd_o.mul_load = sts_i.mul_done;
        cmd_o.d2_add   = sts_i.mul_done;
      end
      dlta_pkg::ST_SQ_Z: begin
        cmd_o.d2_add = sts_i.mul_done;
      end
      dlta_pkg::ST_CHECK: begin
        cmd_o.mul_op = dlta_pkg::MUL_DEN;
        priority if (sts_i.d2_gt_rq) begin
          cmd_o.c_load = 1'b1;
          cmd_o.c_sel  = dlta_pkg::C_ZERO;
        end else if (sts_i.d2_zero) begin
          cmd_o.c_load = 1'b1;
          cmd_o.c_sel  = dlta_pkg::C_MAX;
        end else if (sts_i.num_nonpos) begin
          cmd_o.c_load = 1'b1;
          cmd_o.c_sel  = dlta_pkg::C_ZERO;
        end else begin
          cmd_o.mul_load = 1'b1;
        end
      end
      dlta_pkg::ST_DEN: begin
        cmd_o.mul_op    = dlta_pkg::MUL_NUM_B;
        cmd_o.mul_load  = sts_i.mul_done;
        cmd_o.den_store = sts_i.mul_done;
      end
      dlta_pkg::ST_NUM_B: begin
        cmd_o.mul_op   = dlta_pkg::MUL_NUM_P;
        cmd_o.mul_load = sts_i.mul_done;
      end
      dlta_pkg::ST_NUM_P: begin
        cmd_o.div_init = sts_i.mul_done;
      end
      dlta_pkg::ST_DIV: begin
        cmd_o.c_load = sts_i.div_done;
        cmd_o.c_sel  = dlta_pkg::C_QUOT;
      end
      dlta_pkg::ST_WRITE: begin
        cmd_o.out_load = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  `DLTA_ASSERT_IMP(a_out_slot_free, cmd_o.out_load, !out_valid_q || out_ready_i, "result overwritten")
  `DLTA_ASSERT_IMP(a_mul_idle_on_load, cmd_o.mul_load, sts_i.mul_done, "multiplier reloaded while busy")
  `DLTA_ASSERT_IMP(a_div_after_mul, cmd_o.div_init, sts_i.mul_done && sts_i.div_done, "divider start too early")
  `DLTA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "request taken while busy")
  `DLTA_ASSERT_IMP(a_idle_units_quiet, state_q == dlta_pkg::ST_IDLE, sts_i.mul_done && sts_i.div_done, "unit busy in idle")

endmodule

// File: hw/rtl/dynamic_lightmap_texel_accumulate_core.sv
// Flow: a request is taken in idle; the multiply and divide path is skipped when the texel is
// out of radius, at zero distance, or the light has no positive strength.
// A new request is taken only in idle, after the last result is written to a free output slot;
// the full path uses the shared multiplier (16 8-bit digit steps) and the 9-step divider.
// Reset: asynchronous active low; config returns to defaults, running flag cleared.
module dynamic_lightmap_texel_accumulate_core #(
  parameter int unsigned COORD_FRAC_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dlta_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dlta_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  dlta_pkg::texel_req_t            in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output dlta_pkg::texel_rsp_t            out_rsp_o
);

  dlta_pkg::cmd_t cmd;
  dlta_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  dlta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dlta_datapath #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
